@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the physical frame allocator.
// Depends on nothing; every other file of the block imports it.
package pfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_LOG = 5;
  localparam int GRP_WORDS = 16;
  localparam int GRP_LOG = 4;

  localparam int STATUS_W = 3;
  localparam int FADDR_W = 24;
  localparam int COUNT_W = 12;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_NOT_ALLOC  = 3'd4
  } pfa_status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } pfa_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_WORD,
    S_BIT
  } pfa_state_t;

endpackage

@@ rtl/pfa_bitmap_mem.sv @@
// Used-frame bitmap memory, one word of frame bits per entry, registered read.
// Per-word valid bits make a never-written word read as all free. Uses pfa_pkg.
module pfa_bitmap_mem import pfa_pkg::*; #(
  parameter int NWORDS = 128,
  parameter int AW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    vld_r;
  logic [WORD_BITS-1:0] q_r;
  logic                 q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

@@ rtl/pfa_summary.sv @@
// Per-word full flags and the two-level first-fit search over them.
// A group holds GRP_WORDS words; the word search runs on a registered group. Uses pfa_pkg.
module pfa_summary import pfa_pkg::*; #(
  parameter int NWORDS = 128,
  parameter int AW = 7,
  parameter int NGRPS = 8,
  parameter int GW = 3,
  parameter int POOL_FRAMES = 4096,
  parameter int RSVD_FRAMES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd_en,
  input  logic [AW-1:0] upd_idx,
  input  logic          upd_full,
  input  logic [GW-1:0] grp_sel,
  output logic          grp_found,
  output logic [GW-1:0] grp_idx,
  output logic [AW-1:0] word_idx
);

  logic [NWORDS-1:0]          full_r;
  logic [NGRPS*GRP_WORDS-1:0] avail;
  logic [NGRPS-1:0]           grp_any;
  logic [GRP_WORDS-1:0]       sel_words;
  logic [GRP_LOG-1:0]         w_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else if (upd_en) begin
      full_r[upd_idx] <= upd_full;
    end
  end

  // A word takes part only if it holds at least one frame above the reserved region.
  for (genvar i = 0; i < NGRPS * GRP_WORDS; i++) begin : g_avail
    if (i * WORD_BITS < POOL_FRAMES && (i + 1) * WORD_BITS > RSVD_FRAMES &&
        RSVD_FRAMES < POOL_FRAMES) begin : g_elig
      assign avail[i] = ~full_r[i];
    end else begin : g_none
      assign avail[i] = 1'b0;
    end
  end

  for (genvar g = 0; g < NGRPS; g++) begin : g_grp
    assign grp_any[g] = |avail[g*GRP_WORDS +: GRP_WORDS];
  end

  always_comb begin
    grp_idx = '0;
    for (int g = NGRPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_idx = GW'(g);
      end
    end
  end

  assign grp_found = |grp_any;
  assign sel_words = avail[int'(grp_sel)*GRP_WORDS +: GRP_WORDS];

  always_comb begin
    w_idx = '0;
    for (int w = GRP_WORDS - 1; w >= 0; w--) begin
      if (sel_words[w]) begin
        w_idx = GRP_LOG'(w);
      end
    end
  end

  assign word_idx = AW'(int'(grp_sel) * GRP_WORDS + int'(w_idx));

endmodule

@@ rtl/physical_frame_allocator_core.sv @@
// Top level of the physical frame allocator: request sequencer, used counter, result register.
// Instantiates pfa_bitmap_mem and pfa_summary; uses pfa_pkg.
//
//   Channel  Direction  Beat contents
//   in_      input      req_type, free_address
//   out_     output     status, frame_address, used_count, free_count
//
// An allocate passes through acceptance, group search, word search with bitmap read,
// then bit pick and write-back, where its result is registered. A free, or an allocate
// that finds the pool exhausted, goes from the check straight to the last step.
// Requests are handled one at a time; the bitmap memory's single read-modify-write sets that.
// A result waiting in the output register holds the sequencer in its last step until taken.
// Reset clears the used map and count at once through per-word valid and full flags.
module physical_frame_allocator_core import pfa_pkg::*; #(
  parameter int POOL_FRAMES = 4096,
  parameter int RSVD_FRAMES = 1024,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [31:0]         in_free_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [FADDR_W-1:0]  out_frame_address,
  output logic [COUNT_W-1:0]  out_used_count,
  output logic [COUNT_W-1:0]  out_free_count
);

  localparam int NWORDS = (POOL_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NGRPS = (NWORDS + GRP_WORDS - 1) / GRP_WORDS;
  localparam int GW = (NGRPS > 1) ? $clog2(NGRPS) : 1;
  localparam int PBL = $clog2(PAGE_BYTES);
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int AVAIL = (POOL_FRAMES > RSVD_FRAMES) ?
                         (POOL_FRAMES - RSVD_FRAMES) : 0;

  pfa_state_t state_r, state_nxt;

  logic                 req_r;
  logic [31:0]          addr_r;
  logic                 err_r;
  pfa_status_t          err_code_r;
  logic [GW-1:0]        grp_r;
  logic [AW-1:0]        widx_r;
  logic [WORD_LOG-1:0]  fbit_r;
  logic [CW-1:0]        used_cnt_r, used_cnt_nxt;

  logic                 out_valid_r;
  pfa_status_t          out_status_r;
  logic [FADDR_W-1:0]   out_faddr_r;
  logic [COUNT_W-1:0]   out_used_r;
  logic [COUNT_W-1:0]   out_free_r;

  logic                 grp_found;
  logic [GW-1:0]        grp_idx;
  logic [AW-1:0]        word_idx;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 full_new;
  logic                 finish;

  logic                 misal;
  logic                 rng;
  logic [63:0]          fr64;
  logic [WORD_BITS-1:0] resmask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_LOG-1:0]  pick;
  logic                 bit_set;
  logic [WORD_LOG-1:0]  bsel;
  logic [63:0]          fa64;
  pfa_status_t          status_now;
  logic [31:0]          free_wide;

  pfa_bitmap_mem #(
    .NWORDS(NWORDS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(widx_r),
    .wr_data(wr_data)
  );

  pfa_summary #(
    .NWORDS(NWORDS),
    .AW(AW),
    .NGRPS(NGRPS),
    .GW(GW),
    .POOL_FRAMES(POOL_FRAMES),
    .RSVD_FRAMES(RSVD_FRAMES)
  ) u_sum (
    .clk(clk),
    .rst_n(rst_n),
    .upd_en(wr_en),
    .upd_idx(widx_r),
    .upd_full(full_new),
    .grp_sel(grp_r),
    .grp_found(grp_found),
    .grp_idx(grp_idx),
    .word_idx(word_idx)
  );

  assign misal = |addr_r[PBL-1:0];
  assign fr64 = {32'd0, addr_r} >> PBL;
  assign rng = fr64 >= 64'(POOL_FRAMES);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (req_r == REQ_ALLOC && grp_found) begin
          state_nxt = S_WORD;
        end else begin
          state_nxt = S_BIT;
        end
      end
      S_WORD: begin
        state_nxt = S_BIT;
      end
      S_BIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = word_idx;
    finish   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CHK: begin
        rd_en   = (req_r == REQ_FREE) && !misal && !rng;
        rd_addr = AW'(fr64 >> WORD_LOG);
      end
      S_WORD: begin
        rd_en = 1'b1;
      end
      S_BIT: begin
        finish = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      resmask[j] = (int'(widx_r) * WORD_BITS + j < RSVD_FRAMES) ||
                   (int'(widx_r) * WORD_BITS + j >= POOL_FRAMES);
    end
  end

  assign cand = ~rd_data & ~resmask;

  always_comb begin
    pick = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = WORD_LOG'(j);
      end
    end
  end

  assign bit_set = rd_data[fbit_r];
  assign bsel = (req_r == REQ_ALLOC) ? pick : fbit_r;

  always_comb begin
    wr_data = rd_data;
    wr_data[bsel] = (req_r == REQ_ALLOC);
  end

  assign full_new = (req_r == REQ_ALLOC) ? &(wr_data | resmask) : 1'b0;
  assign wr_en = finish && !err_r && ((req_r == REQ_ALLOC) || bit_set);

  always_comb begin
    if (err_r) begin
      status_now = err_code_r;
    end else if (req_r == REQ_FREE && !bit_set) begin
      status_now = ST_NOT_ALLOC;
    end else begin
      status_now = ST_OK;
    end
  end

  always_comb begin
    used_cnt_nxt = used_cnt_r;
    if (wr_en) begin
      if (req_r == REQ_ALLOC) begin
        used_cnt_nxt = used_cnt_r + CW'(1);
      end else if (used_cnt_r != '0) begin
        used_cnt_nxt = used_cnt_r - CW'(1);
      end
    end
  end

  assign fa64 = 64'(int'(widx_r) * WORD_BITS + int'(pick)) << PBL;
  assign free_wide = 32'(AVAIL) - 32'(used_cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      used_cnt_r <= used_cnt_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      addr_r <= in_free_address;
    end
    if (state_r == S_CHK) begin
      grp_r  <= grp_idx;
      widx_r <= AW'(fr64 >> WORD_LOG);
      fbit_r <= fr64[WORD_LOG-1:0];
      if (req_r == REQ_ALLOC) begin
        err_r      <= !grp_found;
        err_code_r <= ST_EXHAUSTED;
      end else begin
        err_r      <= misal || rng;
        err_code_r <= misal ? ST_MISALIGNED : ST_RANGE;
      end
    end
    if (state_r == S_WORD) begin
      widx_r <= word_idx;
    end
    if (finish) begin
      out_status_r <= status_now;
      out_faddr_r  <= (!err_r && req_r == REQ_ALLOC) ? fa64[FADDR_W-1:0] : '0;
      out_used_r   <= COUNT_W'(32'(used_cnt_nxt));
      out_free_r   <= free_wide[COUNT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_faddr_r;
  assign out_used_count    = out_used_r;
  assign out_free_count    = out_free_r;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for physical_frame_allocator_core: a directed table and random
// requests of every kind, scored against the table's expected results or a bitmap predictor. Depends on pfa_pkg.
module testbench;
  import pfa_pkg::*;

  localparam int POOL_FRAMES = 4096;
  localparam int RSVD_FRAMES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int ALLOCATABLE = (POOL_FRAMES > RSVD_FRAMES) ?
                               (POOL_FRAMES - RSVD_FRAMES) : 0;
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    pfa_status_t          status;
    logic [FADDR_W-1:0]   frame_address;
    logic [COUNT_W-1:0]   used_count;
    logic [COUNT_W-1:0]   free_count;
  } frame_result_t;

  typedef struct {
    pfa_req_t      req;
    logic [31:0]   addr;
    bit            typed;
    frame_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_req_type = 1'b0;
  logic [31:0] in_free_address = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FADDR_W-1:0] out_frame_address;
  logic [COUNT_W-1:0] out_used_count;
  logic [COUNT_W-1:0] out_free_count;

  bit frame_in_use [POOL_FRAMES];
  int frames_held = 0;
  int held_frames [$];
  logic [31:0] last_released = '0;
  frame_result_t expected_results [$];
  stim_row_t directed_rows [$];

  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int status_seen [8];
  int peak_held = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int mode_cycles = 0;
  int stall_run = 0;
  frame_result_t oldest_expected;

  physical_frame_allocator_core #(
    .POOL_FRAMES(POOL_FRAMES),
    .RSVD_FRAMES(RSVD_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_free_address(in_free_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_frame_address(out_frame_address),
    .out_used_count(out_used_count),
    .out_free_count(out_free_count)
  );

  always #5 clk = ~clk;

  function automatic frame_result_t predict_frame_request(pfa_req_t req, logic [31:0] addr);
    frame_result_t r;
    logic [31:0] frame_no;
    bit found;
    int idx;
    r.status = ST_OK;
    r.frame_address = '0;
    found = 1'b0;
    idx = -1;
    frame_no = addr / 32'(PAGE_BYTES);
    if (req == REQ_ALLOC) begin
      for (int i = RSVD_FRAMES; i < POOL_FRAMES && !found; i++) begin
        if (!frame_in_use[i]) begin
          frame_in_use[i] = 1'b1;
          frames_held++;
          r.frame_address = FADDR_W'(i * PAGE_BYTES);
          held_frames.push_back(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_EXHAUSTED;
      end
    end else if ((addr % 32'(PAGE_BYTES)) != 0) begin
      r.status = ST_MISALIGNED;
    end else if (frame_no >= POOL_FRAMES) begin
      r.status = ST_RANGE;
    end else if (!frame_in_use[frame_no]) begin
      r.status = ST_NOT_ALLOC;
    end else begin
      frame_in_use[frame_no] = 1'b0;
      if (frames_held > 0) begin
        frames_held--;
      end
      foreach (held_frames[k]) begin
        if (held_frames[k] == frame_no) begin
          idx = k;
        end
      end
      if (idx >= 0) begin
        held_frames.delete(idx);
      end
    end
    r.used_count = COUNT_W'(frames_held);
    r.free_count = COUNT_W'((ALLOCATABLE >= frames_held) ? (ALLOCATABLE - frames_held) : 0);
    if (frames_held > peak_held) begin
      peak_held = frames_held;
    end
    return r;
  endfunction

  task automatic add_row(input pfa_req_t req, input logic [31:0] addr, input bit typed,
                         input pfa_status_t status, input logic [FADDR_W-1:0] faddr,
                         input int used, input int free);
    stim_row_t row;
    row.req = req;
    row.addr = addr;
    row.typed = typed;
    row.want.status = status;
    row.want.frame_address = faddr;
    row.want.used_count = COUNT_W'(used);
    row.want.free_count = COUNT_W'(free);
    directed_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string detail);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, detail);
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(16, 40);
        3, 4:    gap = $urandom_range(5, 15);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_request(input pfa_req_t req, input logic [31:0] addr, input bit typed,
                              input frame_result_t want);
    frame_result_t predicted;
    pace_sender();
    in_valid <= 1'b1;
    in_req_type <= req;
    in_free_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_frame_request(req, addr);
    expected_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic send_random(input int free_pct);
    pfa_req_t req;
    logic [31:0] addr;
    int pick;
    req = REQ_FREE;
    addr = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < free_pct && held_frames.size() > 0) begin
      addr = held_frames[$urandom_range(0, held_frames.size() - 1)] * PAGE_BYTES;
      last_released = addr;
    end else if (pick < 80) begin
      req = REQ_ALLOC;
    end else begin
      case ($urandom_range(0, 4))
        0: addr = $urandom;
        1: addr = addr - (addr % 32'(PAGE_BYTES));
        2: addr = $urandom_range(0, POOL_FRAMES - 1) * PAGE_BYTES;
        3: begin
          if (held_frames.size() > 0) begin
            addr = held_frames[$urandom_range(0, held_frames.size() - 1)] * PAGE_BYTES;
          end
          addr = addr - (addr % 32'(PAGE_BYTES)) + $urandom_range(1, PAGE_BYTES - 1);
        end
        default: addr = last_released;
      endcase
    end
    send_request(req, addr, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(20, 120);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (mode_cycles % 3 == 0);
      default: begin
        out_ready <= (stall_run == 0);
        stall_run <= (stall_run == 0) ? $urandom_range(4, 20) : stall_run - 1;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_checked++;
      if (out_status < 8) begin
        status_seen[out_status]++;
      end
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat status=%0d addr=%h used=%0d free=%0d",
                                out_status, out_frame_address, out_used_count,
                                out_free_count));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_status !== oldest_expected.status ||
            out_frame_address !== oldest_expected.frame_address ||
            out_used_count !== oldest_expected.used_count ||
            out_free_count !== oldest_expected.free_count) begin
          note_mismatch($sformatf(
            "expected status=%0d addr=%h used=%0d free=%0d, got status=%0d addr=%h used=%0d free=%0d",
            oldest_expected.status, oldest_expected.frame_address,
            oldest_expected.used_count, oldest_expected.free_count,
            out_status, out_frame_address, out_used_count, out_free_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    add_row(REQ_FREE,  32'h0040_0000, 1, ST_NOT_ALLOC,  '0, 0, 3072);
    add_row(REQ_FREE,  32'h0000_0000, 1, ST_NOT_ALLOC,  '0, 0, 3072);
    add_row(REQ_FREE,  32'h0000_0001, 1, ST_MISALIGNED, '0, 0, 3072);
    add_row(REQ_FREE,  32'hFFFF_FFFF, 1, ST_MISALIGNED, '0, 0, 3072);
    add_row(REQ_FREE,  32'hFFFF_F000, 1, ST_RANGE,      '0, 0, 3072);
    add_row(REQ_FREE,  32'h0100_0000, 1, ST_RANGE,      '0, 0, 3072);
    add_row(REQ_FREE,  32'h00FF_F000, 1, ST_NOT_ALLOC,  '0, 0, 3072);
    add_row(REQ_ALLOC, 32'hFFFF_FFFF, 1, ST_OK, 24'h40_0000, 1, 3071);
    add_row(REQ_ALLOC, 32'h0000_0000, 1, ST_OK, 24'h40_1000, 2, 3070);
    add_row(REQ_FREE,  32'h0040_0000, 1, ST_OK,         '0, 1, 3071);
    add_row(REQ_FREE,  32'h0040_0000, 1, ST_NOT_ALLOC,  '0, 1, 3071);
    add_row(REQ_ALLOC, 32'h0040_0000, 1, ST_OK, 24'h40_0000, 2, 3070);
    add_row(REQ_FREE,  32'h003F_F000, 1, ST_NOT_ALLOC,  '0, 2, 3070);
    add_row(REQ_FREE,  32'h0040_0800, 1, ST_MISALIGNED, '0, 2, 3070);
    add_row(REQ_ALLOC, 32'h5555_5555, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_ALLOC, 32'hAAAA_AAAA, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_FREE,  32'h0040_1000, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_ALLOC, 32'h0000_0000, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_FREE,  32'h0040_2000, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_FREE,  32'h00FF_FFFF, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_FREE,  32'h0000_1000, 0, ST_OK,         '0, 0, 0);
    add_row(REQ_ALLOC, 32'h0000_0000, 0, ST_OK,         '0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].addr, directed_rows[i].typed,
                   directed_rows[i].want);
    end

    repeat (400) send_random(35);
    repeat (330) send_random(60);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests and checked %0d result beats; peak of %0d frames held.",
             requests_sent, results_checked, peak_held);
    $display("Status mix: ok %0d, exhausted %0d, misaligned %0d, range %0d, not allocated %0d.",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_MISALIGNED],
             status_seen[ST_RANGE], status_seen[ST_NOT_ALLOC]);
    if (mismatches == 0 && results_checked == requests_sent) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d of %0d results received", mismatches, results_checked,
               requests_sent);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
